// ----- rtl/core/aprp_pkg.sv -----
// Shared types and constants of the packet receiver parser.
package aprp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PosW = 16;
  localparam int unsigned OffsetW = 32;
  localparam int unsigned LenW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CODE_START = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CODE_END   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CODE_DATA  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TAG_SIZE   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TAG_NAME   = 3'd4;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_START   = 2'd1,
    KIND_END     = 2'd2,
    KIND_DATA    = 2'd3
  } kind_e;

  // Where a byte sits in its packet
  typedef enum logic [2:0] {
    POS_HEAD   = 3'd0,
    POS_SEQ    = 3'd1,
    POS_LEN_HI = 3'd2,
    POS_LEN_LO = 3'd3,
    POS_BODY   = 3'd4
  } pos_cls_e;

  // TLV field phase in a start packet
  typedef enum logic [1:0] {
    PH_TYPE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] code_start;
    logic [ByteW-1:0] code_end;
    logic [ByteW-1:0] code_data;
    logic [ByteW-1:0] tag_size;
    logic [ByteW-1:0] tag_name;
  } cfg_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    pos_cls_e         pos;
    kind_e            kind;
  } item_t;

endpackage

// ----- rtl/core/aprp_front.sv -----
// Front end: packet framing and control byte classification.
module aprp_front import aprp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             push_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             last_byte_i,
  output item_t            item_o
);

  logic [PosW-1:0] pos_q, pos_d;
  kind_e           kind_q, kind_d;
  kind_e           head_kind;
  pos_cls_e        pos_cls;

  always_comb begin
    if (pos_q == PosW'(0))      pos_cls = POS_HEAD;
    else if (pos_q == PosW'(1)) pos_cls = POS_SEQ;
    else if (pos_q == PosW'(2)) pos_cls = POS_LEN_HI;
    else if (pos_q == PosW'(3)) pos_cls = POS_LEN_LO;
    else                        pos_cls = POS_BODY;
  end

  // start wins over end, end over data
  always_comb begin
    if (data_byte_i == cfg_i.code_start)     head_kind = KIND_START;
    else if (data_byte_i == cfg_i.code_end)  head_kind = KIND_END;
    else if (data_byte_i == cfg_i.code_data) head_kind = KIND_DATA;
    else                                     head_kind = KIND_UNKNOWN;
  end

  always_comb begin
    pos_d  = pos_q;
    kind_d = kind_q;
    if (push_i) begin
      if (pos_cls == POS_HEAD) kind_d = head_kind;
      if (last_byte_i) pos_d = '0;
      else if (pos_q != {PosW{1'b1}}) pos_d = pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      kind_q <= KIND_UNKNOWN;
    end else begin
      pos_q  <= pos_d;
      kind_q <= kind_d;
    end
  end

  assign item_o.data = data_byte_i;
  assign item_o.last = last_byte_i;
  assign item_o.pos  = pos_cls;
  assign item_o.kind = (pos_cls == POS_HEAD) ? head_kind : kind_q;

endmodule

// ----- rtl/core/aprp_queue.sv -----
// Two-entry queue between front and back.
module aprp_queue import aprp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  avail_o,
  output item_t item_o
);

  item_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/core/aprp_back.sv -----
// Back end: TLV and data packet execution with the result register.
module aprp_back import aprp_pkg::*; #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               avail_i,
  input  item_t              item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               payload_valid_o,
  output logic [ByteW-1:0]   payload_byte_o,
  output logic [OffsetW-1:0] payload_offset_o,
  output logic               name_valid_o,
  output logic [ByteW-1:0]   name_byte_o,
  output logic               packet_done_o,
  output logic [1:0]         packet_kind_o,
  output logic               accepted_o,
  output logic [31:0]        file_size_o,
  output logic [ByteW-1:0]   next_sequence_o
);

  logic                 seq_ok_q, seq_ok_d;
  logic [ByteW-1:0]     exp_seq_q, exp_seq_d;
  logic [LenW-1:0]      len_q, len_d;
  logic [LenW-1:0]      pcnt_q, pcnt_d;
  logic [SIZE_BITS-1:0] size_q, size_d;
  logic [OffsetW-1:0]   offset_q, offset_d;
  phase_e               phase_q, phase_d;
  logic [ByteW-1:0]     tag_q, tag_d;
  logic [ByteW-1:0]     left_q, left_d;
  logic [ByteW-1:0]     left_dec;
  logic [SIZE_BITS+7:0] size_shift;
  logic [63:0]          size_wide;

  logic                 pv, nv, acc;
  logic [OffsetW-1:0]   po;
  logic                 out_valid_q;

  assign pop_o      = avail_i && (!out_valid_q || !out_stall_i);
  assign left_dec   = left_q - ByteW'(1);
  assign size_shift = {size_q, item_i.data};
  assign size_wide  = 64'(size_d);

  always_comb begin
    seq_ok_d  = seq_ok_q;
    exp_seq_d = exp_seq_q;
    len_d     = len_q;
    pcnt_d    = pcnt_q;
    size_d    = size_q;
    offset_d  = offset_q;
    phase_d   = phase_q;
    tag_d     = tag_q;
    left_d    = left_q;
    pv        = 1'b0;
    po        = '0;
    nv        = 1'b0;
    acc       = 1'b0;

    if (item_i.pos == POS_HEAD) begin
      seq_ok_d = 1'b0;
      len_d    = '0;
      pcnt_d   = '0;
      phase_d  = PH_TYPE;
      tag_d    = '0;
      left_d   = '0;
      if (item_i.kind == KIND_START) offset_d = '0;
    end else if (item_i.kind == KIND_START) begin
      unique case (phase_q)
        PH_TYPE: begin
          tag_d   = item_i.data;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          left_d = item_i.data;
          if (tag_q == cfg_i.tag_size) size_d = '0;
          phase_d = (item_i.data == '0) ? PH_TYPE : PH_VALUE;
        end
        default: begin
          // size tag takes priority over an equal name tag
          if (tag_q == cfg_i.tag_size) size_d = size_shift[SIZE_BITS-1:0];
          else if (tag_q == cfg_i.tag_name) nv = 1'b1;
          left_d = left_dec;
          if (left_dec == '0) phase_d = PH_TYPE;
        end
      endcase
    end else if (item_i.kind == KIND_DATA) begin
      unique case (item_i.pos)
        POS_SEQ: begin
          seq_ok_d = (item_i.data == exp_seq_q);
          if (item_i.data == exp_seq_q) exp_seq_d = exp_seq_q + ByteW'(1);
        end
        POS_LEN_HI: len_d = {item_i.data, 8'h00};
        POS_LEN_LO: len_d = {len_q[LenW-1:8], item_i.data};
        default: begin
          if (seq_ok_q && (pcnt_q < len_q)) begin
            pv       = 1'b1;
            po       = offset_q;
            offset_d = offset_q + OffsetW'(1);
            pcnt_d   = pcnt_q + LenW'(1);
          end
        end
      endcase
    end

    if (item_i.last) begin
      case (item_i.kind) inside
        KIND_START, KIND_END: acc = 1'b1;
        KIND_DATA:            acc = seq_ok_d;
        default:              acc = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_ok_q    <= 1'b0;
      exp_seq_q   <= '0;
      len_q       <= '0;
      pcnt_q      <= '0;
      size_q      <= '0;
      offset_q    <= '0;
      phase_q     <= PH_TYPE;
      tag_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        seq_ok_q  <= seq_ok_d;
        exp_seq_q <= exp_seq_d;
        len_q     <= len_d;
        pcnt_q    <= pcnt_d;
        size_q    <= size_d;
        offset_q  <= offset_d;
        phase_q   <= phase_d;
        tag_q     <= tag_d;
        left_q    <= left_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register: payload, name byte, packet status, file size, next sequence
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      payload_valid_o  <= pv;
      payload_byte_o   <= pv ? item_i.data : '0;
      payload_offset_o <= po;
      name_valid_o     <= nv;
      name_byte_o      <= nv ? item_i.data : '0;
      packet_done_o    <= item_i.last;
      packet_kind_o    <= item_i.last ? item_i.kind : KIND_UNKNOWN;
      accepted_o       <= acc;
      file_size_o      <= size_wide[31:0];
      next_sequence_o  <= exp_seq_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/app_packet_receiver_parser_core.sv -----
// Packet receiver parser top level: configuration, front end, queue, back end.
// Path: an accepted request is written into the queue, and the back end pops it
//   into the result register once that register is empty or not stalled.
// Throughput: one byte per cycle; the front takes a byte while the queue holds
//   fewer than two entries, the back pops whenever its result register frees.
// Reset: asynchronous, active low; all parse state clears, configuration
//   registers return to start 2, end 3, data 1, size tag 0, name tag 1.
module app_packet_receiver_parser_core import aprp_pkg::*; #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  // input request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   data_byte_i,
  input  logic               last_byte_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               payload_valid_o,
  output logic [ByteW-1:0]   payload_byte_o,
  output logic [OffsetW-1:0] payload_offset_o,
  output logic               name_valid_o,
  output logic [ByteW-1:0]   name_byte_o,
  output logic               packet_done_o,
  output logic [1:0]         packet_kind_o,
  output logic               accepted_o,
  output logic [31:0]        file_size_o,
  output logic [ByteW-1:0]   next_sequence_o
);

  cfg_t  cfg_q;
  item_t front_item, back_item;
  logic  push, q_full, q_avail, pop;

  // Configuration registers; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_start <= 8'd2;
      cfg_q.code_end   <= 8'd3;
      cfg_q.code_data  <= 8'd1;
      cfg_q.tag_size   <= 8'd0;
      cfg_q.tag_name   <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CODE_START: cfg_q.code_start <= cfg_wdata_i;
        CFG_CODE_END:   cfg_q.code_end   <= cfg_wdata_i;
        CFG_CODE_DATA:  cfg_q.code_data  <= cfg_wdata_i;
        CFG_TAG_SIZE:   cfg_q.tag_size   <= cfg_wdata_i;
        CFG_TAG_NAME:   cfg_q.tag_name   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A request enters when the queue has room.
  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  // Front: byte position tracking and packet kind from the control byte.
  aprp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .item_o      (front_item)
  );

  // Decouples framing from execution so either side can stall alone.
  aprp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .avail_o (q_avail),
    .item_o  (back_item)
  );

  // Back: sequence check, TLV parse, payload offsets, result register.
  aprp_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .avail_i          (q_avail),
    .item_i           (back_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .payload_valid_o  (payload_valid_o),
    .payload_byte_o   (payload_byte_o),
    .payload_offset_o (payload_offset_o),
    .name_valid_o     (name_valid_o),
    .name_byte_o      (name_byte_o),
    .packet_done_o    (packet_done_o),
    .packet_kind_o    (packet_kind_o),
    .accepted_o       (accepted_o),
    .file_size_o      (file_size_o),
    .next_sequence_o  (next_sequence_o)
  );

endmodule
